// ----- src/hcp_pkg.sv -----
`default_nettype none

package hcp_pkg;

  localparam int unsigned PixW  = 32;
  localparam int unsigned CompW = 8;
  localparam int unsigned WideW = 16;
  localparam int unsigned PosW  = 4;
  localparam int unsigned TopW  = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PixW-1:0] RedReset   = 32'h00ff_0000;
  localparam logic [PixW-1:0] GreenReset = 32'h0000_ff00;
  localparam logic [PixW-1:0] BlueReset  = 32'h0000_00ff;

  localparam logic [CompW-1:0] CharHash   = 8'h23;
  localparam logic [CompW-1:0] AlphaOpaque = 8'hff;
  localparam logic [PosW-1:0]  PosMax     = 4'd15;
  localparam logic [PosW-1:0]  PosLastRgb  = 4'd6;
  localparam logic [PosW-1:0]  PosLastRgba = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_BITS   = 3'd0,
    REG_GREEN_BITS = 3'd1,
    REG_BLUE_BITS  = 3'd2,
    REG_TRUE_COLOR = 3'd3,
    REG_ALPHA_PIX  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] run;
    logic [TopW-1:0] top;
  } mask_info_t;

  typedef struct packed {
    mask_info_t red;
    mask_info_t green;
    mask_info_t blue;
    mask_info_t alpha;
    logic       true_color;
    logic       alpha_in_pixel;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [CompW-1:0] r;
    logic [CompW-1:0] g;
    logic [CompW-1:0] b;
    logic [CompW-1:0] a;
  } color_t;

endpackage

`default_nettype wire

// ----- src/hcp_cfg.sv -----
`default_nettype none

module hcp_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [hcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hcp_pkg::PixW-1:0]     cfg_data_i,
  output hcp_pkg::cfg_t                     cfg_o
);
  import hcp_pkg::*;

  logic [PixW-1:0] red_q, red_d;
  logic [PixW-1:0] green_q, green_d;
  logic [PixW-1:0] blue_q, blue_d;
  logic            tc_q, tc_d;
  logic            aip_q, aip_d;
  cfg_t            info_q, info_d;

  // Lowest contiguous run of set bits and the index of its top bit.
  function automatic mask_info_t mask_info(input logic [PixW-1:0] m);
    logic [PixW-1:0] lowbit;
    logic [PixW-1:0] run;
    logic [PixW-1:0] hot;
    mask_info_t      mi;
    lowbit = m & (~m + {{(PixW-1){1'b0}}, 1'b1});
    run    = m & ~(m + lowbit);
    hot    = run & ~(run >> 1);
    mi.run = run;
    mi.top = '0;
    for (int i = 0; i < PixW; i++) begin
      if (hot[i]) begin
        mi.top = mi.top | TopW'(i);
      end
    end
    return mi;
  endfunction

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    tc_d    = tc_q;
    aip_d   = aip_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RED_BITS:   red_d   = cfg_data_i;
        REG_GREEN_BITS: green_d = cfg_data_i;
        REG_BLUE_BITS:  blue_d  = cfg_data_i;
        REG_TRUE_COLOR: tc_d    = cfg_data_i[0];
        REG_ALPHA_PIX:  aip_d   = cfg_data_i[0];
        default: ;
      endcase
    end
    info_d.red            = mask_info(red_d);
    info_d.green          = mask_info(green_d);
    info_d.blue           = mask_info(blue_d);
    info_d.alpha          = mask_info(~(red_d | green_d | blue_d));
    info_d.true_color     = tc_d;
    info_d.alpha_in_pixel = aip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q                 <= RedReset;
      green_q               <= GreenReset;
      blue_q                <= BlueReset;
      tc_q                  <= 1'b1;
      aip_q                 <= 1'b0;
      info_q.red            <= mask_info(RedReset);
      info_q.green          <= mask_info(GreenReset);
      info_q.blue           <= mask_info(BlueReset);
      info_q.alpha          <= mask_info(~(RedReset | GreenReset | BlueReset));
      info_q.true_color     <= 1'b1;
      info_q.alpha_in_pixel <= 1'b0;
    end else begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      tc_q    <= tc_d;
      aip_q   <= aip_d;
      info_q  <= info_d;
    end
  end

  assign cfg_o = info_q;

endmodule

`default_nettype wire

// ----- src/hcp_parse.sv -----
`default_nettype none

module hcp_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [hcp_pkg::CompW-1:0]  char_code_i,
  input  wire logic                       last_char_i,
  output      logic                       color_valid_o,
  input  wire logic                       color_ready_i,
  output hcp_pkg::color_t                 color_o
);
  import hcp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PixW-1:0] acc_q, acc_d;
  logic            err_q, err_d;
  logic            cv_q, cv_d;
  color_t          color_q, color_d;

  logic            accept;
  logic            is_hex;
  logic [3:0]      digit;
  logic [PixW-1:0] acc_n;
  logic            err_n;
  logic [23:0]     rgb;

  assign in_ready_o = !cv_q || color_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_hex = 1'b1;
    digit  = '0;
    if (char_code_i inside {[8'h30:8'h39]}) begin
      digit = 4'(char_code_i - 8'h30);
    end else if (char_code_i inside {[8'h61:8'h66]}) begin
      digit = 4'(char_code_i - 8'h57);
    end else if (char_code_i inside {[8'h41:8'h46]}) begin
      digit = 4'(char_code_i - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    acc_n = acc_q;
    err_n = err_q;
    if (pos_q == '0) begin
      if (char_code_i != CharHash) begin
        err_n = 1'b1;
      end
    end else if (pos_q <= PosLastRgba) begin
      if (is_hex) begin
        acc_n = {acc_q[PixW-5:0], digit};
      end else begin
        err_n = 1'b1;
      end
    end else begin
      err_n = 1'b1;
    end

    rgb       = (pos_q == PosLastRgba) ? acc_n[31:8] : acc_n[23:0];
    color_d.ok = !err_n && (pos_q == PosLastRgb || pos_q == PosLastRgba);
    color_d.r = color_d.ok ? rgb[23:16] : '0;
    color_d.g = color_d.ok ? rgb[15:8] : '0;
    color_d.b = color_d.ok ? rgb[7:0] : '0;
    color_d.a = !color_d.ok ? '0 : (pos_q == PosLastRgba) ? acc_n[7:0] : AlphaOpaque;

    pos_d = pos_q;
    acc_d = acc_q;
    err_d = err_q;
    if (accept) begin
      if (last_char_i) begin
        pos_d = '0;
        acc_d = '0;
        err_d = 1'b0;
      end else begin
        pos_d = (pos_q == PosMax) ? PosMax : pos_q + 4'd1;
        acc_d = acc_n;
        err_d = err_n;
      end
    end

    cv_d = cv_q;
    if (accept && last_char_i) begin
      cv_d = 1'b1;
    end else if (color_ready_i) begin
      cv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      err_q <= 1'b0;
      cv_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
      err_q <= err_d;
      cv_q  <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_char_i) begin
      color_q <= color_d;
    end
  end

  assign color_valid_o = cv_q;
  assign color_o       = color_q;

endmodule

`default_nettype wire

// ----- src/hcp_place.sv -----
`default_nettype none

module hcp_place (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire hcp_pkg::cfg_t              cfg_i,
  input  wire logic                       color_valid_i,
  output      logic                       color_ready_o,
  input  wire hcp_pkg::color_t            color_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic                       parse_ok_o,
  output      logic                       needs_allocation_o,
  output      logic [hcp_pkg::PixW-1:0]   pixel_value_o,
  output      logic [hcp_pkg::WideW-1:0]  red_wide_o,
  output      logic [hcp_pkg::WideW-1:0]  green_wide_o,
  output      logic [hcp_pkg::WideW-1:0]  blue_wide_o,
  output      logic [hcp_pkg::WideW-1:0]  alpha_wide_o
);
  import hcp_pkg::*;

  logic             ov_q, ov_d;
  logic             ok_q, alloc_q;
  logic [PixW-1:0]  pix_q, pix_d;
  logic [WideW-1:0] rw_q, gw_q, bw_q, aw_q;
  logic             load;

  // Put the component MSB on the run's top bit, then keep only the run.
  function automatic logic [PixW-1:0] place(input logic [CompW-1:0] v,
                                            input mask_info_t mi);
    logic [PixW+CompW-2:0] sh;
    sh = {{(PixW-1){1'b0}}, v} << mi.top;
    return sh[PixW+CompW-2:CompW-1] & mi.run;
  endfunction

  assign color_ready_o = !ov_q || out_ready_i;
  assign load          = color_valid_i && color_ready_o;

  always_comb begin
    pix_d = '0;
    if (cfg_i.true_color) begin
      pix_d = place(color_i.r, cfg_i.red) | place(color_i.g, cfg_i.green)
            | place(color_i.b, cfg_i.blue);
      if (cfg_i.alpha_in_pixel) begin
        pix_d = pix_d | place(color_i.a, cfg_i.alpha);
      end
    end
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q    <= color_i.ok;
      alloc_q <= color_i.ok && !cfg_i.true_color;
      pix_q   <= pix_d;
      rw_q    <= {color_i.r, color_i.r};
      gw_q    <= {color_i.g, color_i.g};
      bw_q    <= {color_i.b, color_i.b};
      aw_q    <= {color_i.a, color_i.a};
    end
  end

  assign out_valid_o        = ov_q;
  assign parse_ok_o         = ok_q;
  assign needs_allocation_o = alloc_q;
  assign pixel_value_o      = pix_q;
  assign red_wide_o         = rw_q;
  assign green_wide_o       = gw_q;
  assign blue_wide_o        = bw_q;
  assign alpha_wide_o       = aw_q;

endmodule

`default_nettype wire

// ----- src/hex_color_to_pixel_packer.sv -----
`default_nettype none

// Parses a "#RRGGBB" or "#RRGGBBAA" string one character per beat and packs
// the color into a pixel through the red, green and blue masks (lowest
// contiguous run of each), plus alpha in the other bits if enabled, in
// true-color mode. One character is taken every cycle while in_ready_o is
// high; the result of a string is held in the parser's result register,
// loaded when its last character is accepted, then in the placement register.
// Mask runs are decoded ahead of the configuration registers, so a write
// applies to every beat placed after the edge that makes it. Write the
// configuration only while no string is in flight.
module hex_color_to_pixel_packer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [hcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hcp_pkg::PixW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [hcp_pkg::CompW-1:0]    char_code_i,
  input  wire logic                         last_char_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         parse_ok_o,
  output      logic                         needs_allocation_o,
  output      logic [hcp_pkg::PixW-1:0]     pixel_value_o,
  output      logic [hcp_pkg::WideW-1:0]    red_wide_o,
  output      logic [hcp_pkg::WideW-1:0]    green_wide_o,
  output      logic [hcp_pkg::WideW-1:0]    blue_wide_o,
  output      logic [hcp_pkg::WideW-1:0]    alpha_wide_o
);
  import hcp_pkg::*;

  cfg_t   cfg;
  color_t color;
  logic   color_valid;
  logic   color_ready;

  hcp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .last_char_i   (last_char_i),
    .color_valid_o (color_valid),
    .color_ready_i (color_ready),
    .color_o       (color)
  );

  hcp_place u_place (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .color_valid_i      (color_valid),
    .color_ready_o      (color_ready),
    .color_i            (color),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .parse_ok_o         (parse_ok_o),
    .needs_allocation_o (needs_allocation_o),
    .pixel_value_o      (pixel_value_o),
    .red_wide_o         (red_wide_o),
    .green_wide_o       (green_wide_o),
    .blue_wide_o        (blue_wide_o),
    .alpha_wide_o       (alpha_wide_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/pixel_packer_checker.sv -----
`timescale 1ns / 100ps

module pixel_packer_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hcp_pkg::PixW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [hcp_pkg::CompW-1:0]   char_code_i,
  input  logic                        last_char_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        parse_ok_i,
  input  logic                        needs_allocation_i,
  input  logic [hcp_pkg::PixW-1:0]    pixel_value_i,
  input  logic [hcp_pkg::WideW-1:0]   red_wide_i,
  input  logic [hcp_pkg::WideW-1:0]   green_wide_i,
  input  logic [hcp_pkg::WideW-1:0]   blue_wide_i,
  input  logic [hcp_pkg::WideW-1:0]   alpha_wide_i,
  output int                          error_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          parsed_o,
  output int                          allocation_o
);
  import hcp_pkg::*;

  typedef struct packed {
    logic              ok;
    logic              alloc;
    logic [PixW-1:0]   pixel;
    logic [WideW-1:0]  red;
    logic [WideW-1:0]  green;
    logic [WideW-1:0]  blue;
    logic [WideW-1:0]  alpha;
  } pixel_result_t;

  logic [PixW-1:0] red_field, green_field, blue_field;
  logic            true_color, alpha_pix;
  logic [PosW-1:0] char_pos;
  logic [PixW-1:0] digit_acc;
  logic            bad_format;
  pixel_result_t   color_q[$];

  function automatic logic [4:0] hex_nibble(input logic [CompW-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // Only the lowest contiguous run of the mask takes the component.
  function automatic logic [PixW-1:0] mask_place(input logic [CompW-1:0] comp,
                                                 input logic [PixW-1:0] mask);
    int          lsb;
    int          run;
    logic [63:0] v;
    lsb = 0;
    run = 0;
    if (mask != '0) begin
      while (!mask[lsb]) lsb++;
    end
    while (lsb + run < PixW && mask[lsb + run]) run++;
    v = 64'(comp);
    if (run < CompW) v = v >> (CompW - run);
    else v = v << (run - CompW);
    v = v << lsb;
    return v[PixW-1:0];
  endfunction

  function automatic pixel_result_t finish_string(input logic [PosW-1:0] pos);
    pixel_result_t    res;
    logic [CompW-1:0] r, g, b, a;
    logic [23:0]      rgb;
    res = '0;
    if (bad_format || (pos != PosLastRgb && pos != PosLastRgba)) return res;
    if (pos == PosLastRgba) begin
      a   = digit_acc[7:0];
      rgb = digit_acc[31:8];
    end else begin
      a   = AlphaOpaque;
      rgb = digit_acc[23:0];
    end
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    if (true_color) begin
      res.pixel = mask_place(r, red_field) | mask_place(g, green_field)
                | mask_place(b, blue_field);
      if (alpha_pix) begin
        res.pixel |= mask_place(a, ~(red_field | green_field | blue_field));
      end
    end
    res.ok    = 1'b1;
    res.alloc = !true_color;
    res.red   = {r, r};
    res.green = {g, g};
    res.blue  = {b, b};
    res.alpha = {a, a};
    return res;
  endfunction

  task automatic report(input string msg);
    error_count_o++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [PixW-1:0] got,
                             input logic [PixW-1:0] want);
    if (got !== want) report($sformatf("%s got %h, want %h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t   want;
    pixel_result_t   got;
    logic [4:0]      nib;
    logic [PosW-1:0] pos;
    if (!rst_ni) begin
      red_field     = RedReset;
      green_field   = GreenReset;
      blue_field    = BlueReset;
      true_color    = 1'b1;
      alpha_pix     = 1'b0;
      char_pos      = '0;
      digit_acc     = '0;
      bad_format    = 1'b0;
      color_q       = {};
      error_count_o = 0;
      checked_o     = 0;
      parsed_o      = 0;
      allocation_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (color_q.size() == 0) begin
          report($sformatf("result with nothing expected, pixel %h", pixel_value_i));
        end else begin
          want = color_q.pop_front();
          got  = '{parse_ok_i, needs_allocation_i, pixel_value_i, red_wide_i,
                   green_wide_i, blue_wide_i, alpha_wide_i};
          checked_o++;
          if (want.ok) parsed_o++;
          if (want.alloc) allocation_o++;
          check_field("parse_ok", 32'(got.ok), 32'(want.ok));
          check_field("needs_allocation", 32'(got.alloc), 32'(want.alloc));
          check_field("pixel_value", got.pixel, want.pixel);
          check_field("red_wide", 32'(got.red), 32'(want.red));
          check_field("green_wide", 32'(got.green), 32'(want.green));
          check_field("blue_wide", 32'(got.blue), 32'(want.blue));
          check_field("alpha_wide", 32'(got.alpha), 32'(want.alpha));
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_RED_BITS:   red_field   = cfg_data_i;
          REG_GREEN_BITS: green_field = cfg_data_i;
          REG_BLUE_BITS:  blue_field  = cfg_data_i;
          REG_TRUE_COLOR: true_color  = cfg_data_i[0];
          REG_ALPHA_PIX:  alpha_pix   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pos = char_pos;
        if (pos == '0) begin
          if (char_code_i != CharHash) bad_format = 1'b1;
        end else if (pos <= PosLastRgba) begin
          nib = hex_nibble(char_code_i);
          if (!nib[4]) bad_format = 1'b1;
          else digit_acc = {digit_acc[PixW-5:0], nib[3:0]};
        end else begin
          bad_format = 1'b1;
        end
        if (pos != PosMax) char_pos = pos + 1'b1;
        if (last_char_i) begin
          color_q.push_back(finish_string(pos));
          char_pos   = '0;
          digit_acc  = '0;
          bad_format = 1'b0;
        end
      end
    end
    pending_o = color_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hcp_pkg::*;

  typedef logic [CompW-1:0] text_t[$];

  localparam int Phases      = 10;
  localparam int PhaseChars  = 180;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  cfg_reg_e         cfg_index_i = REG_RED_BITS;
  logic [PixW-1:0]  cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CompW-1:0] char_code_i = '0;
  logic             last_char_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b1;
  logic             parse_ok_o;
  logic             needs_allocation_o;
  logic [PixW-1:0]  pixel_value_o;
  logic [WideW-1:0] red_wide_o, green_wide_o, blue_wide_o, alpha_wide_o;

  int error_count, pending, checked, parsed, allocation;
  int in_gap_pct  = 0;
  int out_gap_pct = 0;
  int chars_sent  = 0;
  int settings_applied = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  hex_color_to_pixel_packer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .char_code_i, .last_char_i,
    .out_valid_o, .out_ready_i, .parse_ok_o, .needs_allocation_o,
    .pixel_value_o, .red_wide_o, .green_wide_o, .blue_wide_o, .alpha_wide_o
  );

  pixel_packer_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .char_code_i, .last_char_i,
    .out_valid_i(out_valid_o), .out_ready_i, .parse_ok_i(parse_ok_o),
    .needs_allocation_i(needs_allocation_o), .pixel_value_i(pixel_value_o),
    .red_wide_i(red_wide_o), .green_wide_i(green_wide_o),
    .blue_wide_i(blue_wide_o), .alpha_wide_i(alpha_wide_o),
    .error_count_o(error_count), .pending_o(pending), .checked_o(checked),
    .parsed_o(parsed), .allocation_o(allocation)
  );

  function automatic logic [CompW-1:0] hex_char();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [CompW-1:0] non_hex_char();
    case ($urandom_range(0, 3))
      0:       return CompW'($urandom_range(8'h00, 8'h2f));
      1:       return CompW'($urandom_range(8'h3a, 8'h40));
      2:       return CompW'($urandom_range(8'h47, 8'h60));
      default: return CompW'($urandom_range(8'h67, 8'hff));
    endcase
  endfunction

  function automatic logic [PixW-1:0] random_mask();
    int          w;
    int          lsb;
    logic [63:0] m;
    w   = $urandom_range(1, 32);
    lsb = $urandom_range(0, 31);
    m   = ((64'd1 << w) - 64'd1) << lsb;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return m[PixW-1:0];
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [PixW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic apply_settings(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                input logic [PixW-1:0] b, input logic tc, input logic ap);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(REG_RED_BITS, r);
    write_reg(REG_GREEN_BITS, g);
    write_reg(REG_BLUE_BITS, b);
    write_reg(REG_TRUE_COLOR, PixW'(tc));
    write_reg(REG_ALPHA_PIX, PixW'(ap));
    repeat (2) @(negedge clk_i);
    settings_applied++;
  endtask

  task automatic send_beat(input logic [CompW-1:0] c, input logic last);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    char_code_i = c;
    last_char_i = last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_beat(t[i], i == t.size() - 1);
    in_valid_i = 1'b0;
  endtask

  task automatic send_literal(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  // Mostly well-formed colors; the rest are damaged, mis-sized or noise.
  task automatic make_random_string(output text_t t);
    int kind;
    int n;
    t    = {};
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      t.push_back(CharHash);
      n = $urandom_range(0, 1) ? 6 : 8;
      repeat (n) t.push_back(hex_char());
      if (kind >= 70) t[$urandom_range(0, n)] = non_hex_char();
    end else if (kind < 86) begin
      t.push_back(CharHash);
      do n = $urandom_range(0, 18); while (n == 6 || n == 8);
      repeat (n) t.push_back(hex_char());
    end else if (kind < 92) begin
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          t.push_back(CharHash);
          t.push_back("0");
          t.push_back("x");
        end
        2: begin
          t.push_back(CharHash);
          case ($urandom_range(0, 3))
            0:       t.push_back(" ");
            1:       t.push_back("+");
            2:       t.push_back("-");
            default: t.push_back(8'h09);
          endcase
        end
        default: begin
          t.push_back(" ");
          t.push_back(CharHash);
        end
      endcase
      repeat (6) t.push_back(hex_char());
    end else begin
      repeat ($urandom_range(1, 20)) t.push_back(CompW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    text_t t;
    int    phase_chars;
    int    gap_choice[4] = '{0, 10, 30, 60};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_literal("#09afAF");
    send_literal("#FfFfFf00");
    send_literal("#/:@G`g");
    send_literal("Z");

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       apply_settings('1, '0, '0, 1'b1, 1'b0);
        1:       apply_settings(32'h8000_0000, 32'h0000_0001, 32'h0000_0f00, 1'b1, 1'b1);
        2:       apply_settings(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, 1'b1, 1'b1);
        3:       apply_settings(RedReset, GreenReset, BlueReset, 1'b1, 1'b1);
        4:       apply_settings(random_mask(), random_mask(), random_mask(), 1'b0,
                                1'($urandom_range(0, 1)));
        default: apply_settings(random_mask(), random_mask(), random_mask(),
                                $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      endcase
      if (p == Phases - 1) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct  = gap_choice[$urandom_range(0, 3)];
        out_gap_pct = gap_choice[$urandom_range(0, 3)];
      end
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        make_random_string(t);
        send_text(t);
        phase_chars += t.size();
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Sent %0d characters over %0d register settings", chars_sent, settings_applied);
    $display("Checked %0d strings: %0d parsed, %0d needing colormap allocation",
             checked, parsed, allocation);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
